FILE: src/indexed_ordered_list_defines.svh
// ----------------------------------------------------------------------------
// indexed_ordered_list assertion macros
// Shared assertion forms for the ordered list block.
// ----------------------------------------------------------------------------
`ifndef INDEXED_ORDERED_LIST_DEFINES_SVH
`define INDEXED_ORDERED_LIST_DEFINES_SVH

// condition holds at every clock edge out of reset
`define IOL_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define IOL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/iol_pkg.sv
// ----------------------------------------------------------------------------
// iol_pkg
// Types and codes for the indexed ordered list block.
// ----------------------------------------------------------------------------
package iol_pkg;

  localparam int ACT_W    = 4;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 5;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_BACK  = 4'd0,
    ACT_PUSH_FRONT = 4'd1,
    ACT_POP_BACK   = 4'd2,
    ACT_POP_FRONT  = 4'd3,
    ACT_GET_FRONT  = 4'd4,
    ACT_GET_BACK   = 4'd5,
    ACT_GET_AT     = 4'd6,
    ACT_INSERT_AT  = 4'd7,
    ACT_DELETE_AT  = 4'd8,
    ACT_CLEAR      = 4'd9
  } act_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_UP,
    S_FILL,
    S_DOWN,
    S_GET,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [ACT_W-1:0]          action;
    logic signed [VALUE_W-1:0] value;
    logic [INDEX_W-1:0]        index;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] read_value;
    logic [STATUS_W-1:0]       status;
    logic [COUNT_W-1:0]        entry_count;
    logic                      is_empty;
  } out_item_t;

endpackage

FILE: src/indexed_ordered_list.sv
// ----------------------------------------------------------------------------
// indexed_ordered_list
// Bounded ordered list of signed 32-bit values kept in a small on-chip memory.
// ----------------------------------------------------------------------------
// Each request gives one result item. The entries live in one memory with one
// write and one registered read per cycle, and a small sequencer moves one
// entry per cycle to open or close a gap. After acceptance a request that
// reads or moves nothing (errors, clear, removing the back entry, unused codes)
// goes from S_EXEC straight to S_FIN, where its result is loaded into the
// output register; gets pass S_GET and appends S_FILL on the way. Each entry
// moved passes through S_UP (insert) or S_DOWN (delete): an insert at position
// p with n entries moves n-p of them, a delete at p moves n-p-1. A request
// waits in S_FIN only while the previous result is still held at the output.
// The input is taken again the cycle after a result is loaded, even while
// that result still waits at the output. Memory contents are undefined after
// reset; positions are only read after they were written, so no clearing pass is needed.
`include "indexed_ordered_list_defines.svh"

module indexed_ordered_list #(
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  iol_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output iol_pkg::out_item_t  out_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > iol_pkg::INDEX_W) ? CW : iol_pkg::INDEX_W;

  iol_pkg::state_t    state_r, state_nxt;
  iol_pkg::in_item_t  req_r, req_nxt;
  iol_pkg::out_item_t out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [CW-1:0]      t_r, t_nxt;
  logic [CW-1:0]      pos_r, pos_nxt;
  logic [iol_pkg::STATUS_W-1:0]      st_r, st_nxt;
  logic signed [iol_pkg::VALUE_W-1:0] rdv_r, rdv_nxt;

  logic [iol_pkg::VALUE_W-1:0] mem [DEPTH];
  logic [iol_pkg::VALUE_W-1:0] rdata_r;
  logic                        wr_en;
  logic [AW-1:0]               wr_addr;
  logic [iol_pkg::VALUE_W-1:0] wr_data;
  logic [AW-1:0]               rd_addr;

  logic          do_ins, do_del, do_get;
  logic [CW-1:0] op_pos;
  logic [XW-1:0] idx_x, cnt_x;
  logic          full, empty;
  logic [CW-1:0] wr_lim;
  logic          fin_held;

  assign in_stall  = (state_r != iol_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign idx_x = XW'(req_r.index);
  assign cnt_x = XW'(cnt_r);
  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);

  // inserting may write one slot past the live entries
  assign wr_lim   = cnt_r + CW'(state_r == iol_pkg::S_FILL || state_r == iol_pkg::S_UP);
  assign fin_held = (state_r == iol_pkg::S_FIN) && out_valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= iol_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    out_r <= out_nxt;
    t_r   <= t_nxt;
    pos_r <= pos_nxt;
    st_r  <= st_nxt;
    rdv_r <= rdv_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r & out_stall;
    cnt_nxt       = cnt_r;
    t_nxt         = t_r;
    pos_nxt       = pos_r;
    st_nxt        = st_r;
    rdv_nxt       = rdv_r;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = rdata_r;
    rd_addr       = '0;
    do_ins        = 1'b0;
    do_del        = 1'b0;
    do_get        = 1'b0;
    op_pos        = '0;

    unique case (state_r)
      iol_pkg::S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data;
          state_nxt = iol_pkg::S_EXEC;
        end
      end

      iol_pkg::S_EXEC: begin
        st_nxt    = iol_pkg::ST_OK;
        rdv_nxt   = '0;
        state_nxt = iol_pkg::S_FIN;
        unique case (req_r.action)
          iol_pkg::ACT_PUSH_BACK, iol_pkg::ACT_PUSH_FRONT: begin
            if (full) begin
              st_nxt = iol_pkg::ST_FULL;
            end else begin
              do_ins = 1'b1;
              op_pos = (req_r.action == iol_pkg::ACT_PUSH_BACK) ? cnt_r : '0;
            end
          end
          iol_pkg::ACT_POP_BACK, iol_pkg::ACT_POP_FRONT: begin
            if (empty) begin
              st_nxt = iol_pkg::ST_EMPTY;
            end else begin
              do_del = 1'b1;
              op_pos = (req_r.action == iol_pkg::ACT_POP_BACK) ? cnt_r - 1'b1 : '0;
            end
          end
          iol_pkg::ACT_GET_FRONT, iol_pkg::ACT_GET_BACK: begin
            if (empty) begin
              st_nxt = iol_pkg::ST_EMPTY;
            end else begin
              do_get = 1'b1;
              op_pos = (req_r.action == iol_pkg::ACT_GET_BACK) ? cnt_r - 1'b1 : '0;
            end
          end
          iol_pkg::ACT_GET_AT, iol_pkg::ACT_DELETE_AT: begin
            priority if (empty) begin
              st_nxt = iol_pkg::ST_EMPTY;
            end else if (idx_x >= cnt_x) begin
              st_nxt = iol_pkg::ST_RANGE;
            end else begin
              do_get = (req_r.action == iol_pkg::ACT_GET_AT);
              do_del = (req_r.action == iol_pkg::ACT_DELETE_AT);
              op_pos = CW'(req_r.index);
            end
          end
          iol_pkg::ACT_INSERT_AT: begin
            // range is checked ahead of fullness
            priority if (idx_x > cnt_x) begin
              st_nxt = iol_pkg::ST_RANGE;
            end else if (full) begin
              st_nxt = iol_pkg::ST_FULL;
            end else begin
              do_ins = 1'b1;
              op_pos = CW'(req_r.index);
            end
          end
          iol_pkg::ACT_CLEAR: begin
            cnt_nxt = '0;
          end
          default: begin
          end
        endcase

        if (do_get) begin
          rd_addr   = op_pos[AW-1:0];
          state_nxt = iol_pkg::S_GET;
        end
        if (do_ins) begin
          pos_nxt = op_pos;
          t_nxt   = cnt_r;
          if (cnt_r == op_pos) begin
            state_nxt = iol_pkg::S_FILL;
          end else begin
            rd_addr   = AW'(cnt_r - 1'b1);
            state_nxt = iol_pkg::S_UP;
          end
        end
        if (do_del) begin
          t_nxt = op_pos;
          if (CW'(op_pos + 1'b1) == cnt_r) begin
            cnt_nxt = cnt_r - 1'b1;
          end else begin
            rd_addr   = AW'(op_pos + 1'b1);
            state_nxt = iol_pkg::S_DOWN;
          end
        end
      end

      // move entry t-1 up into t, read the next one down in the same cycle
      iol_pkg::S_UP: begin
        wr_en   = 1'b1;
        wr_addr = t_r[AW-1:0];
        t_nxt   = t_r - 1'b1;
        if (CW'(t_r - 1'b1) == pos_r) begin
          state_nxt = iol_pkg::S_FILL;
        end else begin
          rd_addr = AW'(t_r - CW'(2));
        end
      end

      iol_pkg::S_FILL: begin
        wr_en     = 1'b1;
        wr_addr   = pos_r[AW-1:0];
        wr_data   = req_r.value;
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = iol_pkg::S_FIN;
      end

      // move entry t+1 down into t
      iol_pkg::S_DOWN: begin
        wr_en   = 1'b1;
        wr_addr = t_r[AW-1:0];
        t_nxt   = t_r + 1'b1;
        if (CW'(t_r + CW'(2)) == cnt_r) begin
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = iol_pkg::S_FIN;
        end else begin
          rd_addr = AW'(t_r + CW'(2));
        end
      end

      iol_pkg::S_GET: begin
        rdv_nxt   = rdata_r;
        state_nxt = iol_pkg::S_FIN;
      end

      iol_pkg::S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt.read_value  = rdv_r;
          out_nxt.status      = st_r;
          out_nxt.entry_count = iol_pkg::COUNT_W'(cnt_r);
          out_nxt.is_empty    = (cnt_r == '0);
          out_valid_nxt       = 1'b1;
          state_nxt           = iol_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = iol_pkg::S_IDLE;
      end
    endcase
  end

  `IOL_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= CW'(DEPTH), "entry count above depth")
  `IOL_ASSERT_ALWAYS(a_wr_in_range, !wr_en || (CW'(wr_addr) < wr_lim), "write beyond live entries")
  `IOL_ASSERT_ALWAYS(a_up_above_pos, state_r != iol_pkg::S_UP || t_r > pos_r, "shift up passed the insert position")
  `IOL_ASSERT_NEXT(a_fin_holds, fin_held, state_r == iol_pkg::S_FIN, "result dropped while output held")

endmodule
